// ===== hw/rtl/lcdns_pkg.sv =====
// shared types, constants and the init nibble table for the char lcd nibble sequencer
// used by lcdns_front, lcdns_queue, lcdns_back and the top level
package lcdns_pkg;

  localparam int COLUMNS_DEF  = 16;
  localparam int POS_W        = 5;    // holds a line position up to 31
  localparam int IDX_W        = POS_W + 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int INIT_NIBBLES = 12;

  localparam logic [7:0] BYTE_CLEAR  = 8'h01;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_CURSOR = 8'h80;

  localparam logic [12:0] WAIT_NIB   = 13'd50;
  localparam logic [12:0] WAIT_BYTE  = 13'd100;
  localparam logic [12:0] WAIT_CLEAR = 13'd2100;

  typedef enum logic [2:0] {
    REQ_INIT   = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_CURSOR = 3'd2,
    REQ_CHAR   = 3'd3,
    REQ_LINE   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_PAD  = 2'd2
  } cmd_op_t;

  // one queued command: a byte, a run of pad bytes or the whole init sequence
  typedef struct packed {
    cmd_op_t          op;
    logic             rs;
    logic [7:0]       data;
    logic             clr;
    logic [POS_W-1:0] cnt;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } nib_t;

  function automatic nib_t init_step(input logic [3:0] idx);
    nib_t s;
    s = '{rs: 1'b0, nib: 4'h0, wait_before: 16'd0, wait_after: WAIT_NIB, last: 1'b0};
    unique case (idx)
      4'd0: begin
        s.nib = 4'h3;
        s.wait_before = 16'd50000;
        s.wait_after = 13'd5050;
      end
      4'd1, 4'd2: begin
        s.nib = 4'h3;
        s.wait_after = 13'd200;
      end
      4'd3: s.nib = 4'h2;
      4'd4: s.nib = 4'h2;
      4'd5: begin
        s.nib = 4'h8;
        s.wait_after = WAIT_BYTE;
      end
      4'd6: s.nib = 4'h0;
      4'd7: begin
        s.nib = 4'hC;
        s.wait_after = WAIT_BYTE;
      end
      4'd8: s.nib = 4'h0;
      4'd9: begin
        s.nib = 4'h6;
        s.wait_after = WAIT_BYTE;
      end
      4'd10: s.nib = 4'h0;
      4'd11: begin
        s.nib = 4'h1;
        s.wait_after = WAIT_CLEAR;
      end
      default: s.nib = 4'h0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// the first nibble word of a request passes through the queue, the back-end command
// register and the output register before it shows on out_tvalid. a byte expands to two
// nibble words (one per nibble, set by the back-end nibble counter), init to 12, a pad run
// to two per space; a line start holds in_tready low until its second command is queued.
// up to four commands queue between front and back. reset: synchronous active-low rst_n
// clears ready, line state, the queue, the back-end state and the output valid; no clearing pass
module char_lcd_nibble_sequencer
  import lcdns_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // col[7:0], row[15:8], char_code[23:16]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // nibble[3:0], wait_before_us[19:4], wait_after_us[32:20], zeros
  output logic [0:0]  out_tuser,  // reg_select[0]
  output logic        out_tlast
);

  logic push, q_full, q_pop, q_empty;
  cmd_t push_cmd, q_cmd;
  nib_t out_nib;

  lcdns_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req_type  (in_tuser),
    .col       (in_tdata[7:0]),
    .row       (in_tdata[15:8]),
    .char_code (in_tdata[23:16]),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  lcdns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_nib   (out_nib)
  );

  assign out_tdata = {7'd0, out_nib.wait_after, out_nib.wait_before, out_nib.nib};
  assign out_tuser = out_nib.rs;
  assign out_tlast = out_nib.last;

endmodule

// ===== hw/rtl/lcdns_front.sv =====
// request decode: keeps ready and line state, turns each accepted word into zero, one or two queued commands
// depends on lcdns_pkg
module lcdns_front
  import lcdns_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [7:0] col,
  input  logic [7:0] row,
  input  logic [7:0] char_code,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  logic             ready_flag_r, ready_flag_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pend_r, pend_nxt;
  cmd_t             pend_cmd_r, pend_cmd_nxt;

  logic       accept;
  logic       first_v;
  cmd_t       first_cmd;
  logic       row_c;
  logic [4:0] col_c;
  logic [7:0] cur_byte, line_byte;

  assign in_ready = !pend_r && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    row_c = (row <= 8'd1) ? row[0] : 1'b0;
    col_c = (col < 8'(COLUMNS)) ? col[4:0] : 5'd0;
    cur_byte  = BYTE_CURSOR | {1'b0, row_c, 6'd0} | {3'd0, col_c};
    line_byte = BYTE_CURSOR | {1'b0, row_c, 6'd0};
  end

  always_comb begin
    ready_flag_nxt = ready_flag_r;
    pos_nxt        = pos_r;
    pend_nxt       = pend_r;
    pend_cmd_nxt   = pend_cmd_r;
    first_v        = 1'b0;
    first_cmd      = '{op: CMD_BYTE, rs: 1'b0, data: 8'd0, clr: 1'b0, cnt: '0, last: 1'b1};

    if (pend_r && !q_full) begin
      pend_nxt = 1'b0;
    end

    if (accept) begin
      unique case (req_type)
        REQ_INIT: begin
          first_v        = 1'b1;
          first_cmd.op   = CMD_INIT;
          ready_flag_nxt = 1'b1;
          pos_nxt        = '0;
        end
        REQ_CLEAR: begin
          first_v        = ready_flag_r;
          first_cmd.data = BYTE_CLEAR;
          first_cmd.clr  = 1'b1;
        end
        REQ_CURSOR: begin
          first_v        = 1'b1;
          first_cmd.data = cur_byte;
        end
        REQ_CHAR: begin
          first_v        = 1'b1;
          first_cmd.rs   = 1'b1;
          first_cmd.data = char_code;
        end
        REQ_LINE: begin
          if (ready_flag_r) begin
            if (pos_r == '0) begin
              // line start: cursor move first, then the character or a full pad run
              first_v        = 1'b1;
              first_cmd.data = line_byte;
              first_cmd.last = 1'b0;
              pend_nxt       = 1'b1;
              pend_cmd_nxt   = '{op: CMD_BYTE, rs: 1'b1, data: char_code, clr: 1'b0,
                                 cnt: '0, last: 1'b1};
              if (char_code != 8'd0) begin
                pos_nxt = POS_W'(1);
              end else begin
                pend_cmd_nxt.op   = CMD_PAD;
                pend_cmd_nxt.data = BYTE_SPACE;
                pend_cmd_nxt.cnt  = POS_W'(COLUMNS);
              end
            end else if (char_code != 8'd0) begin
              if (pos_r < POS_W'(COLUMNS)) begin
                first_v        = 1'b1;
                first_cmd.rs   = 1'b1;
                first_cmd.data = char_code;
                pos_nxt        = pos_r + POS_W'(1);
              end
            end else begin
              first_v        = (pos_r < POS_W'(COLUMNS));
              first_cmd.op   = CMD_PAD;
              first_cmd.rs   = 1'b1;
              first_cmd.data = BYTE_SPACE;
              first_cmd.cnt  = POS_W'(COLUMNS) - pos_r;
              pos_nxt        = '0;
            end
          end
        end
        default: first_v = 1'b0;
      endcase
    end
  end

  assign push     = (accept && first_v) || (pend_r && !q_full);
  assign push_cmd = pend_r ? pend_cmd_r : first_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_flag_r <= 1'b0;
      pos_r        <= '0;
      pend_r       <= 1'b0;
    end else begin
      ready_flag_r <= ready_flag_nxt;
      pos_r        <= pos_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
  end

endmodule

// ===== hw/rtl/lcdns_queue.sv =====
// short command queue between the decode front and the nibble back end
// depends on lcdns_pkg
module lcdns_queue
  import lcdns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/lcdns_back.sv =====
// nibble sequencer: expands queued commands into timed nibble words behind an output register
// depends on lcdns_pkg
module lcdns_back
  import lcdns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output nib_t out_nib
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  nib_t             nib_r, nib_nxt;

  logic [IDX_W-1:0] total;
  logic             final_nib, emit, load;
  nib_t             cur;

  always_comb begin
    unique case (cmd_r.op)
      CMD_INIT: total = IDX_W'(INIT_NIBBLES);
      CMD_PAD:  total = {cmd_r.cnt, 1'b0};
      default:  total = IDX_W'(2);
    endcase
    final_nib = (idx_r == total - IDX_W'(1));

    if (cmd_r.op == CMD_INIT) begin
      cur = init_step(idx_r[3:0]);
    end else begin
      cur.rs          = cmd_r.rs;
      cur.nib         = idx_r[0] ? cmd_r.data[3:0] : cmd_r.data[7:4];
      cur.wait_before = 16'd0;
      cur.wait_after  = !idx_r[0] ? WAIT_NIB : (cmd_r.clr ? WAIT_CLEAR : WAIT_BYTE);
      cur.last        = 1'b0;
    end
    cur.last = cmd_r.last && final_nib;
  end

  assign emit  = (state_r == ST_RUN) && (!valid_r || out_ready);
  assign load  = !q_empty && ((state_r == ST_IDLE) || (emit && final_nib));
  assign q_pop = load;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    if (load) begin
      state_nxt = ST_RUN;
      cmd_nxt   = q_cmd;
      idx_nxt   = '0;
    end else if (emit && final_nib) begin
      state_nxt = ST_IDLE;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    nib_nxt   = emit ? cur : nib_r;
    valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    nib_r <= nib_nxt;
  end

  assign out_valid = valid_r;
  assign out_nib   = nib_r;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for char_lcd_nibble_sequencer: directed and random request words,
// each nibble word checked against an in-bench prediction of the lcd nibble sequence
// depends on lcdns_pkg and the char_lcd_nibble_sequencer top level
`timescale 1ns / 100ps

module tb;
  import lcdns_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          ROW_CELLS    = 16;
  localparam int          ITEMS_TARGET = 470;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_LIMIT  = 200000;
  localparam int          TAIL_CYCLES  = 16;
  localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
  localparam logic [7:0]  CODE_END      = 8'h00;
  localparam logic [15:0] POWER_WAIT_US = 16'd50000;

  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_COIN   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_HEAVY  = 2'd3
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // col[7:0], row[15:8], char_code[23:16]
  logic [2:0]  in_tuser = '0;   // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // nibble[3:0], wait_before_us[19:4], wait_after_us[32:20], zeros
  logic [0:0]  out_tuser;       // reg_select[0]
  logic        out_tlast;

  char_lcd_nibble_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_HALF) clk = ~clk;

  // predicted display state and the nibble words still owed by the block
  logic             lcd_ready;
  logic [POS_W-1:0] cells_written;
  nib_t             nibble_q[$];
  nib_t             req_pulses[0:33];
  int               req_n;

  int  errors = 0;
  int  words_sent = 0;
  int  nibbles_checked = 0;
  int  burst_left = 0;
  bit  tx_steady = 1'b0;
  bit  rx_hold = 1'b0;
  event hold_go;

  task automatic add_pulse(input logic rs, input logic [3:0] nib, input logic [15:0] wait_pre,
                           input logic [12:0] after);
    req_pulses[req_n] = '{rs: rs, nib: nib, wait_before: wait_pre, wait_after: after,
                          last: 1'b0};
    req_n++;
  endtask

  task automatic add_byte(input logic rs, input logic [7:0] b, input logic [12:0] extra);
    add_pulse(rs, b[7:4], 16'd0, WAIT_NIB);
    add_pulse(rs, b[3:0], 16'd0, WAIT_BYTE + extra);
  endtask

  task automatic add_cursor(input logic [7:0] col, input logic [7:0] row);
    logic [7:0] c;
    logic [7:0] r;
    c = (col < ROW_CELLS) ? col : 8'd0;
    r = (row <= 8'd1) ? row : 8'd0;
    add_byte(1'b0, BYTE_CURSOR | (r * 8'h40 + c), 13'd0);
  endtask

  task automatic predict_nibbles(input logic [2:0] req, input logic [7:0] col,
                                 input logic [7:0] row, input logic [7:0] ch);
    req_n = 0;
    case (req)
      REQ_INIT: begin
        add_pulse(1'b0, 4'h3, POWER_WAIT_US, 13'd5050);
        add_pulse(1'b0, 4'h3, 16'd0, 13'd200);
        add_pulse(1'b0, 4'h3, 16'd0, 13'd200);
        add_pulse(1'b0, 4'h2, 16'd0, WAIT_NIB);
        add_byte(1'b0, 8'h28, 13'd0);
        add_byte(1'b0, 8'h0C, 13'd0);
        add_byte(1'b0, 8'h06, 13'd0);
        add_byte(1'b0, BYTE_CLEAR, WAIT_CLEAR - WAIT_BYTE);
        lcd_ready = 1'b1;
        cells_written = '0;
      end
      REQ_CLEAR: begin
        if (lcd_ready) add_byte(1'b0, BYTE_CLEAR, WAIT_CLEAR - WAIT_BYTE);
      end
      REQ_CURSOR: add_cursor(col, row);
      REQ_CHAR: add_byte(1'b1, ch, 13'd0);
      REQ_LINE: begin
        if (lcd_ready) begin
          if (cells_written == 0) begin
            add_cursor(8'd0, row);
            if (ch != CODE_END) begin
              add_byte(1'b1, ch, 13'd0);
              cells_written = POS_W'(1);
            end else begin
              // end code with no open line: a full row of spaces
              repeat (ROW_CELLS) add_byte(1'b1, BYTE_SPACE, 13'd0);
            end
          end else if (ch != CODE_END) begin
            if (cells_written < ROW_CELLS) begin
              add_byte(1'b1, ch, 13'd0);
              cells_written++;
            end
          end else begin
            while (cells_written < ROW_CELLS) begin
              add_byte(1'b1, BYTE_SPACE, 13'd0);
              cells_written++;
            end
            cells_written = '0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < req_n; i++) begin
      if (i == req_n - 1) req_pulses[i].last = 1'b1;
      nibble_q.push_back(req_pulses[i]);
    end
  endtask

  task automatic compare_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
    end
  endtask

  task automatic check_nibble_word();
    nib_t e;
    if (nibble_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected nibble word, expected none, actual %0h user %0h last %0b",
               $time, out_tdata, out_tuser, out_tlast);
    end else begin
      e = nibble_q.pop_front();
      compare_field("reg_select", e.rs, out_tuser[0]);
      compare_field("nibble", e.nib, out_tdata[3:0]);
      compare_field("wait_before_us", e.wait_before, out_tdata[19:4]);
      compare_field("wait_after_us", e.wait_after, out_tdata[32:20]);
      compare_field("pad bits", 0, out_tdata[39:33]);
      compare_field("last", e.last, out_tlast);
      nibbles_checked++;
    end
  endtask

  // request words are predicted before the nibble word of the same edge is checked
  always @(posedge clk) begin
    if (!rst_n) begin
      lcd_ready = 1'b0;
      cells_written = '0;
    end else begin
      if (in_tvalid && in_tready)
        predict_nibbles(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      if (out_tvalid && out_tready) check_nibble_word();
    end
  end

  // receiver: the stall pattern switches to a randomly chosen mode whenever its current mode runs out
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) != 0);
        default:   out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // long receiver hold-off, released on a rising edge so the receiver reads it cleanly
  initial begin
    forever begin
      @(hold_go);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  task automatic send_word(input logic [2:0] req, input logic [7:0] col, input logic [7:0] row,
                           input logic [7:0] ch);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      if (!tx_steady) begin
        in_tvalid <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {ch, row, col};
    burst_left--;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic test_before_ready();
    send_word(REQ_LINE, 8'd0, 8'd1, 8'h41);
    send_word(REQ_LINE, 8'd0, 8'd0, CODE_END);
    send_word(REQ_CLEAR, 8'd0, 8'd0, 8'd0);
    for (int u = REQ_UNUSED_LO; u <= REQ_UNUSED_HI; u++)
      send_word(u[2:0], 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_cursor_clamp();
    send_word(REQ_CURSOR, 8'h80, 8'h7F, 8'h00);  // both out of range
    send_word(REQ_CURSOR, 8'd15, 8'd1, 8'hFF);   // bottom right corner
    send_word(REQ_CURSOR, 8'd16, 8'hFF, 8'h00);  // one past the row end, row 0xFF out of range
    send_word(REQ_CURSOR, 8'h7F, 8'd2, 8'h00);
  endtask

  task automatic test_write_char();
    send_word(REQ_CHAR, 8'h00, 8'h00, 8'h00);
    send_word(REQ_CHAR, 8'hFF, 8'hFF, 8'hFF);
    send_word(REQ_CHAR, 8'h55, 8'hAA, 8'h5A);
  endtask

  task automatic test_init_clear();
    send_word(REQ_INIT, 8'h00, 8'h00, 8'h00);
    send_word(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_line_basic();
    send_word(REQ_LINE, 8'd0, 8'd1, CODE_END);     // blank row with cursor move
    send_word(REQ_LINE, 8'd0, 8'd0, 8'h48);
    send_word(REQ_LINE, 8'd0, 8'd1, 8'h69);        // row ignored once the line is open
    send_word(REQ_LINE, 8'd0, 8'd0, CODE_END);
    send_word(REQ_LINE, 8'd0, 8'd1, 8'h58);
    send_word(REQ_INIT, 8'd0, 8'd0, 8'd0);         // init closes the open line
    send_word(REQ_LINE, 8'd0, 8'd1, 8'h59);
    send_word(REQ_LINE, 8'd0, 8'd0, CODE_END);
  endtask

  task automatic test_line_overflow();
    for (int k = 0; k < ROW_CELLS + 3; k++) begin
      send_word(REQ_LINE, any_byte(), any_byte(), text_char());
      if (k == 5) send_word(REQ_CLEAR, any_byte(), any_byte(), any_byte());
    end
    send_word(REQ_LINE, any_byte(), any_byte(), CODE_END);  // full line, no padding
  endtask

  task automatic test_backpressure();
    -> hold_go;
    tx_steady = 1'b1;
    burst_left = 0;
    for (int k = 0; k < 40; k++) send_word(REQ_CHAR, any_byte(), any_byte(), any_byte());
    tx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int pick;
    int len;
    while (words_sent < ITEMS_TARGET) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = $urandom_range(0, 20);
        for (int k = 0; k < len; k++) send_word(REQ_LINE, any_byte(), any_byte(), text_char());
        if ($urandom_range(0, 4) != 0) send_word(REQ_LINE, any_byte(), any_byte(), CODE_END);
      end else if (pick < 65) begin
        send_word(REQ_CHAR, any_byte(), any_byte(), any_byte());
      end else if (pick < 75) begin
        send_word(REQ_CURSOR, any_byte(), any_byte(), any_byte());
      end else if (pick < 80) begin
        send_word(REQ_CLEAR, any_byte(), any_byte(), any_byte());
      end else if (pick < 83) begin
        send_word(REQ_INIT, any_byte(), any_byte(), any_byte());
      end else if (pick < 93) begin
        send_word(3'($urandom_range(0, 7)), any_byte(), any_byte(), any_byte());
      end else begin
        send_word(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), any_byte(), any_byte(),
                  any_byte());
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    int guard;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_before_ready();
    test_cursor_clamp();
    test_write_char();
    test_init_clear();
    test_line_basic();
    test_line_overflow();
    test_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_tvalid <= 1'b0;
    guard = 0;
    while (nibble_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (nibble_q.size() != 0) begin
      errors++;
      $display("%0t: nibble words missing, expected %0d more, actual 0",
               $time, nibble_q.size());
    end
    $display("run covered %0d request words (init, clear, cursor, char, line, unused codes)",
             words_sent);
    $display("%0d nibble words checked, %0d mismatches", nibbles_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
